[src/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion, sampled on the rising clock edge, off during reset.
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/tts_pkg.sv]
// Shared constants, operation codes and the store request type of the text terminal engine.
package tts_pkg;

  // Screen and history geometry.
  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int HISTORY_LINES = 256;

  localparam int HL_W  = $clog2(HISTORY_LINES);
  localparam int UL_W  = $clog2(HISTORY_LINES + 1);
  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int CI_W  = $clog2(COLUMNS);
  localparam int RW_W  = $clog2(ROWS);
  localparam int HA_W  = $clog2(HISTORY_LINES * COLUMNS);
  localparam int SA_W  = $clog2(ROWS * COLUMNS);

  localparam int IN_W  = 32;
  localparam int OUT_W = 48;

  // Operation codes.
  localparam logic [3:0] OP_PUT   = 4'd0;
  localparam logic [3:0] OP_BS    = 4'd1;
  localparam logic [3:0] OP_LEFT  = 4'd2;
  localparam logic [3:0] OP_RIGHT = 4'd3;
  localparam logic [3:0] OP_SETC  = 4'd4;
  localparam logic [3:0] OP_SUP   = 4'd5;
  localparam logic [3:0] OP_SDN   = 4'd6;
  localparam logic [3:0] OP_BOT   = 4'd7;
  localparam logic [3:0] OP_CLR   = 4'd8;
  localparam logic [3:0] OP_READ  = 4'd9;

  // Control characters and cell constants.
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  // One access to each store per cycle.
  typedef struct packed {
    logic            h_we;
    logic [HA_W-1:0] h_addr;
    logic [15:0]     h_wdata;
    logic            s_we;
    logic [SA_W-1:0] s_addr;
    logic [15:0]     s_wdata;
  } mem_req_t;

endpackage

[src/tts_store.sv]
// History and screen cell stores, one port each with registered read data.
module tts_store (
  input  logic              clk,
  input  tts_pkg::mem_req_t req,
  output logic [15:0]       h_rdata,
  output logic [15:0]       s_rdata
);
  import tts_pkg::*;

  logic [15:0] hist_mem [HISTORY_LINES*COLUMNS];
  logic [15:0] scr_mem  [ROWS*COLUMNS];

  // History store port.
  always_ff @(posedge clk) begin
    if (req.h_we) begin
      hist_mem[req.h_addr] <= req.h_wdata;
    end
    h_rdata <= hist_mem[req.h_addr];
  end

  // Screen store port.
  always_ff @(posedge clk) begin
    if (req.s_we) begin
      scr_mem[req.s_addr] <= req.s_wdata;
    end
    s_rdata <= scr_mem[req.s_addr];
  end

endmodule

[src/tts_seq.sv]
// Sequencer with the terminal state, the shared history address unit and the result register.
module tts_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [tts_pkg::IN_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [tts_pkg::OUT_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  output tts_pkg::mem_req_t      mem_req,
  input  logic [15:0]            h_rdata,
  input  logic [15:0]            s_rdata
);
  import tts_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_NL       = 5'd1;
  localparam logic [4:0] S_CLRL     = 5'd2;
  localparam logic [4:0] S_CLRA     = 5'd3;
  localparam logic [4:0] S_RD_CLAMP = 5'd4;
  localparam logic [4:0] S_RD_VS    = 5'd5;
  localparam logic [4:0] S_RD_RD    = 5'd6;
  localparam logic [4:0] S_RD_WR    = 5'd7;
  localparam logic [4:0] S_RD_END   = 5'd8;
  localparam logic [4:0] S_CURS_VS  = 5'd9;
  localparam logic [4:0] S_CURS     = 5'd10;
  localparam logic [4:0] S_PUT      = 5'd11;
  localparam logic [4:0] S_BSW      = 5'd12;
  localparam logic [4:0] S_CP_VS    = 5'd13;
  localparam logic [4:0] S_CP_CHK   = 5'd14;
  localparam logic [4:0] S_CP_WR    = 5'd15;
  localparam logic [4:0] S_CP_END   = 5'd16;
  localparam logic [4:0] S_SCR_RD   = 5'd17;
  localparam logic [4:0] S_SCR_CAP  = 5'd18;
  localparam logic [4:0] S_DONE     = 5'd19;

  logic [4:0]       state_r, state_nxt;
  logic [HL_W-1:0]  base_r, base_nxt;
  logic [UL_W-1:0]  used_r, used_nxt;
  logic [7:0]       scroll_r, scroll_nxt;
  logic [HL_W-1:0]  line_r, line_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [15:0]      curs_r, curs_nxt;
  logic             cen_r, cen_nxt;
  logic [7:0]       attr_r, attr_nxt;
  logic [HA_W-1:0]  cnt_r, cnt_nxt;
  logic [RW_W-1:0]  rrow_r, rrow_nxt;
  logic [CI_W-1:0]  rcol_r, rcol_nxt;
  logic [SA_W-1:0]  saddr_r, saddr_nxt;
  logic [UL_W-1:0]  vstart_r, vstart_nxt;
  logic             pend_put_r, pend_put_nxt;
  logic             inc_col_r, inc_col_nxt;
  logic             init_r, init_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic [15:0]      cell_r, cell_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [3:0]       in_op;
  logic [7:0]       in_char;
  logic [7:0]       in_newcol;
  logic [4:0]       in_vrow;
  logic [6:0]       in_vcol;
  logic [15:0]      blank;
  logic [UL_W-1:0]  max_scroll;
  logic [UL_W-1:0]  vstart_calc;
  logic [UL_W+1:0]  vs_lim;
  logic [UL_W-1:0]  line_ext;
  logic [UL_W-1:0]  lrow;
  logic [UL_W:0]    rd_src;
  logic             rd_src_ok;
  logic             cp_ok;
  logic [7:0]       crow;
  logic             drop;
  logic [HL_W-1:0]  nl_line;
  logic [UL_W-1:0]  nl_used;

  // Shared history address unit: ring-mapped line times width plus column.
  logic [HL_W-1:0]  hl_line;
  logic [COL_W-1:0] hl_col;
  logic [HL_W:0]    psum;
  logic [HL_W-1:0]  phys;
  logic [COL_W-1:0] colmod;
  logic [HA_W-1:0]  hist_addr;

  assign in_op     = in_tdata[3:0];
  assign in_char   = in_tdata[11:4];
  assign in_newcol = in_tdata[19:12];
  assign in_vrow   = in_tdata[24:20];
  assign in_vcol   = in_tdata[31:25];

  assign blank = {attr_r, CH_SPACE};

  assign psum   = (HL_W+1)'(base_r) + (HL_W+1)'(hl_line);
  assign phys   = (psum >= (HL_W+1)'(HISTORY_LINES)) ?
                  HL_W'(psum - (HL_W+1)'(HISTORY_LINES)) : HL_W'(psum);
  assign colmod = (hl_col >= COL_W'(COLUMNS)) ? COL_W'(hl_col - COL_W'(COLUMNS)) : hl_col;
  assign hist_addr = HA_W'(HA_W'(phys) * HA_W'(COLUMNS)) + HA_W'(colmod);

  // Scroll limits and the first visible history line.
  assign max_scroll  = (used_r > UL_W'(ROWS)) ? UL_W'(used_r - UL_W'(ROWS)) : '0;
  assign vs_lim      = (UL_W+2)'(ROWS) + (UL_W+2)'(scroll_r);
  assign vstart_calc = ((UL_W+2)'(used_r) > vs_lim) ?
                       UL_W'((UL_W+2)'(used_r) - vs_lim) : '0;

  assign line_ext  = UL_W'(line_r);
  assign lrow      = line_ext - vstart_r;
  assign cp_ok     = (scroll_r == 8'd0) && (line_ext < used_r) &&
                     (col_r < COL_W'(COLUMNS)) && (line_ext >= vstart_r) &&
                     (lrow < UL_W'(ROWS));
  assign rd_src    = (UL_W+1)'(vstart_r) + (UL_W+1)'(rrow_r);
  assign rd_src_ok = rd_src < (UL_W+1)'(used_r);
  assign crow      = 8'(lrow);

  // Newline bookkeeping, including dropping the oldest line at the end of the ring.
  assign drop    = (line_r == HL_W'(HISTORY_LINES - 1));
  assign nl_line = drop ? line_r : HL_W'(line_r + 1'b1);
  assign nl_used = ((UL_W'(nl_line) >= (drop ? UL_W'(used_r - 1'b1) : used_r))) ?
                   UL_W'(UL_W'(nl_line) + 1'b1) : (drop ? UL_W'(used_r - 1'b1) : used_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Address unit input selection.
  always_comb begin
    hl_line = line_r;
    hl_col  = col_r;
    case (state_r)
      S_CLRL:  hl_col  = COL_W'(rcol_r);
      S_RD_RD: begin
        hl_line = HL_W'(rd_src);
        hl_col  = COL_W'(rcol_r);
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    used_nxt     = used_r;
    scroll_nxt   = scroll_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    curs_nxt     = curs_r;
    cen_nxt      = cen_r;
    attr_nxt     = cfg_wr_en ? cfg_wr_data : attr_r;
    cnt_nxt      = cnt_r;
    rrow_nxt     = rrow_r;
    rcol_nxt     = rcol_r;
    saddr_nxt    = saddr_r;
    vstart_nxt   = vstart_r;
    pend_put_nxt = pend_put_r;
    inc_col_nxt  = inc_col_r;
    init_nxt     = init_r;
    ch_nxt       = ch_r;
    cell_nxt     = cell_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    mem_req      = '0;
    mem_req.h_addr = hist_addr;
    mem_req.s_addr = saddr_r;

    case (state_r)
      // Decode an accepted item.
      S_IDLE: begin
        if (in_tvalid) begin
          cell_nxt     = 16'd0;
          pend_put_nxt = 1'b0;
          inc_col_nxt  = 1'b0;
          ch_nxt       = in_char;
          state_nxt    = S_DONE;
          case (in_op)
            OP_PUT: begin
              if (in_char == CH_BS) begin
                if (col_r == '0) begin
                  if (line_r != '0) begin
                    line_nxt  = HL_W'(line_r - 1'b1);
                    col_nxt   = COL_W'(COLUMNS - 1);
                    state_nxt = S_BSW;
                  end
                end else begin
                  col_nxt   = COL_W'(col_r - 1'b1);
                  state_nxt = S_BSW;
                end
              end else if (in_char == CH_LF) begin
                state_nxt = S_NL;
              end else if (in_char == CH_CR) begin
                col_nxt   = '0;
                state_nxt = S_CP_VS;
              end else if (col_r >= COL_W'(COLUMNS)) begin
                pend_put_nxt = 1'b1;
                state_nxt    = S_NL;
              end else begin
                state_nxt = S_PUT;
              end
            end
            OP_BS: begin
              if (col_r == '0) begin
                if (line_r != '0) begin
                  line_nxt  = HL_W'(line_r - 1'b1);
                  col_nxt   = COL_W'(COLUMNS - 1);
                  state_nxt = S_BSW;
                end
              end else begin
                col_nxt   = COL_W'(col_r - 1'b1);
                state_nxt = S_BSW;
              end
            end
            OP_LEFT: begin
              if (col_r != '0) begin
                col_nxt = COL_W'(col_r - 1'b1);
              end else if (line_r != '0) begin
                line_nxt = HL_W'(line_r - 1'b1);
                col_nxt  = COL_W'(COLUMNS - 1);
              end
              state_nxt = (scroll_r == 8'd0) ? S_CURS_VS : S_DONE;
            end
            OP_RIGHT: begin
              if (col_r < COL_W'(COLUMNS - 1)) begin
                col_nxt = COL_W'(col_r + 1'b1);
              end else if (UL_W'(line_ext + 1'b1) < used_r) begin
                col_nxt  = '0;
                line_nxt = HL_W'(line_r + 1'b1);
              end
              state_nxt = (scroll_r == 8'd0) ? S_CURS_VS : S_DONE;
            end
            OP_SETC: begin
              col_nxt   = (in_newcol > 8'(COLUMNS)) ? COL_W'(COLUMNS) : COL_W'(in_newcol);
              state_nxt = (scroll_r == 8'd0) ? S_CURS_VS : S_DONE;
            end
            OP_SUP: begin
              if (max_scroll != '0) begin
                if (UL_W'(scroll_r) < max_scroll) begin
                  scroll_nxt = 8'(scroll_r + 1'b1);
                end
                state_nxt = S_RD_CLAMP;
              end
            end
            OP_SDN: begin
              if (scroll_r != 8'd0) begin
                scroll_nxt = 8'(scroll_r - 1'b1);
                state_nxt  = S_RD_CLAMP;
              end
            end
            OP_BOT: begin
              if (scroll_r != 8'd0) begin
                scroll_nxt = 8'd0;
                state_nxt  = S_RD_CLAMP;
              end
            end
            OP_CLR: begin
              base_nxt   = '0;
              used_nxt   = UL_W'(1);
              scroll_nxt = 8'd0;
              line_nxt   = '0;
              col_nxt    = '0;
              curs_nxt   = 16'd0;
              cnt_nxt    = '0;
              state_nxt  = S_CLRA;
            end
            OP_READ: begin
              if ((int'(in_vrow) < ROWS) && (int'(in_vcol) < COLUMNS)) begin
                saddr_nxt = SA_W'(SA_W'(SA_W'(in_vrow) * SA_W'(COLUMNS)) + SA_W'(in_vcol));
                state_nxt = S_SCR_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // Advance the cursor line, then blank it.
      S_NL: begin
        if (drop) begin
          base_nxt = (base_r == HL_W'(HISTORY_LINES - 1)) ? '0 : HL_W'(base_r + 1'b1);
          if (scroll_r != 8'd0) begin
            scroll_nxt = 8'(scroll_r - 1'b1);
          end
        end
        line_nxt  = nl_line;
        used_nxt  = nl_used;
        col_nxt   = '0;
        rcol_nxt  = '0;
        state_nxt = S_CLRL;
      end

      S_CLRL: begin
        mem_req.h_we    = 1'b1;
        mem_req.h_wdata = blank;
        rcol_nxt        = CI_W'(rcol_r + 1'b1);
        if (rcol_r == CI_W'(COLUMNS - 1)) begin
          if (scroll_r == 8'd0) begin
            state_nxt = S_RD_CLAMP;
          end else begin
            state_nxt = pend_put_r ? S_PUT : S_DONE;
          end
        end
      end

      // Blank the whole history store, one cell a cycle.
      S_CLRA: begin
        mem_req.h_we    = 1'b1;
        mem_req.h_addr  = cnt_r;
        mem_req.h_wdata = blank;
        cnt_nxt         = HA_W'(cnt_r + 1'b1);
        if (cnt_r == HA_W'(HISTORY_LINES * COLUMNS - 1)) begin
          state_nxt = S_RD_CLAMP;
        end
      end

      // Redraw: clamp the scroll, find the first line, then copy cell by cell.
      S_RD_CLAMP: begin
        if (UL_W'(scroll_r) > max_scroll) begin
          scroll_nxt = 8'(max_scroll);
        end
        state_nxt = S_RD_VS;
      end

      S_RD_VS: begin
        vstart_nxt = vstart_calc;
        rrow_nxt   = '0;
        rcol_nxt   = '0;
        saddr_nxt  = '0;
        state_nxt  = S_RD_RD;
      end

      S_RD_RD: begin
        state_nxt = S_RD_WR;
      end

      S_RD_WR: begin
        mem_req.s_we    = 1'b1;
        mem_req.s_wdata = rd_src_ok ? h_rdata : blank;
        saddr_nxt       = SA_W'(saddr_r + 1'b1);
        state_nxt       = S_RD_RD;
        if (rcol_r == CI_W'(COLUMNS - 1)) begin
          rcol_nxt = '0;
          rrow_nxt = RW_W'(rrow_r + 1'b1);
          if (rrow_r == RW_W'(ROWS - 1)) begin
            state_nxt = S_RD_END;
          end
        end else begin
          rcol_nxt = CI_W'(rcol_r + 1'b1);
        end
      end

      S_RD_END: begin
        if (scroll_r == 8'd0) begin
          cen_nxt   = 1'b1;
          state_nxt = S_CURS_VS;
        end else begin
          cen_nxt   = 1'b0;
          state_nxt = pend_put_r ? S_PUT : S_DONE;
        end
      end

      // Cursor register: row relative to the view times width plus column.
      S_CURS_VS: begin
        vstart_nxt = vstart_calc;
        state_nxt  = S_CURS;
      end

      S_CURS: begin
        curs_nxt  = 16'(16'(16'(crow) * 16'(COLUMNS)) + 16'(col_r));
        state_nxt = pend_put_r ? S_PUT : S_DONE;
      end

      // Character write and backspace blanking, then copy to the screen when the cell is in view.
      S_PUT: begin
        mem_req.h_we    = 1'b1;
        mem_req.h_wdata = {attr_r, ch_r};
        pend_put_nxt    = 1'b0;
        inc_col_nxt     = 1'b1;
        state_nxt       = S_CP_VS;
      end

      S_BSW: begin
        mem_req.h_we    = 1'b1;
        mem_req.h_wdata = blank;
        state_nxt       = S_CP_VS;
      end

      S_CP_VS: begin
        vstart_nxt = vstart_calc;
        state_nxt  = S_CP_CHK;
      end

      S_CP_CHK: begin
        if (cp_ok) begin
          saddr_nxt = SA_W'(SA_W'(SA_W'(lrow) * SA_W'(COLUMNS)) + SA_W'(col_r));
          state_nxt = S_CP_WR;
        end else begin
          state_nxt = S_CP_END;
        end
      end

      S_CP_WR: begin
        mem_req.s_we    = 1'b1;
        mem_req.s_wdata = h_rdata;
        state_nxt       = S_CP_END;
      end

      S_CP_END: begin
        if (inc_col_r) begin
          col_nxt = COL_W'(col_r + 1'b1);
        end
        state_nxt = (scroll_r == 8'd0) ? S_CURS_VS : S_DONE;
      end

      // Screen cell read.
      S_SCR_RD: begin
        state_nxt = S_SCR_CAP;
      end

      S_SCR_CAP: begin
        cell_nxt  = s_rdata;
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once free; after reset, go idle with no result.
      S_DONE: begin
        if (init_r) begin
          init_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, scroll_r, (scroll_r == 8'd0), cen_r, curs_r, cell_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, initialised at reset; reset starts the store clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLRA;
      base_r      <= '0;
      used_r      <= UL_W'(1);
      scroll_r    <= 8'd0;
      line_r      <= '0;
      col_r       <= '0;
      curs_r      <= 16'd0;
      cen_r       <= 1'b1;
      attr_r      <= ATTR_RESET;
      cnt_r       <= '0;
      pend_put_r  <= 1'b0;
      inc_col_r   <= 1'b0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      used_r      <= used_nxt;
      scroll_r    <= scroll_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      curs_r      <= curs_nxt;
      cen_r       <= cen_nxt;
      attr_r      <= attr_nxt;
      cnt_r       <= cnt_nxt;
      pend_put_r  <= pend_put_nxt;
      inc_col_r   <= inc_col_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    rrow_r     <= rrow_nxt;
    rcol_r     <= rcol_nxt;
    saddr_r    <= saddr_nxt;
    vstart_r   <= vstart_nxt;
    ch_r       <= ch_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[src/text_terminal_scrollback_engine.sv]
// A character is written to history and, if in view, copied to the screen store.
// A newline blanks the new history line cell by cell and, at the bottom, redraws the screen.
// Redraw walks 2000 screen cells through the one history port, reading then writing each.
// Clear makes 20480 history writes, then the redraw.
// One item at a time; the next is taken once the result register is loaded.
// Reset is synchronous; the same clearing pass then runs, with in_tready low until it ends.
module text_terminal_scrollback_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[3:0], char_code[11:4], new_column[19:12], view_row[24:20], view_col[31:25]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_word[15:0], cursor_position[31:16], cursor_shown[32], at_bottom[33],
  // scroll_amount[41:34], zeros[47:42]
  output logic [47:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import tts_pkg::*;

  mem_req_t    mem_req;
  logic [15:0] h_rdata;
  logic [15:0] s_rdata;

  // Sequencer and terminal state.
  tts_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mem_req    (mem_req),
    .h_rdata    (h_rdata),
    .s_rdata    (s_rdata)
  );

  // Cell stores.
  tts_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .h_rdata(h_rdata),
    .s_rdata(s_rdata)
  );

endmodule

[src/tts_checker.sv]
// Port-level checker for the text terminal engine and its bind to the top level.
`include "assert_macros.svh"

module tts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  import tts_pkg::*;

  // An accepted item keeps the input side closed in the following cycle.
  `TTS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // The bottom flag matches the scroll amount.
  `TTS_ASSERT_IMP(a_bottom_flag, clk, rst_n, out_tvalid, out_tdata[33] == (out_tdata[41:34] == 8'd0), "bottom flag wrong")

  // The cursor is shown exactly when the view is at the bottom.
  `TTS_ASSERT_IMP(a_cursor_shown, clk, rst_n, out_tvalid, out_tdata[32] == out_tdata[33], "cursor visibility wrong")

  // Scrollback never exceeds the history beyond one screen.
  `TTS_ASSERT_IMP(a_scroll_range, clk, rst_n, out_tvalid, int'(out_tdata[41:34]) <= HISTORY_LINES - ROWS, "scroll too far")

  // A stalled result holds.
  `TTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")

endmodule

bind text_terminal_scrollback_engine tts_checker u_tts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
